// ----- sv/qpst_pkg.sv -----
package qpst_pkg;

  // operation codes carried by the input word
  localparam logic [1:0] OP_SPEED = 2'd0;
  localparam logic [1:0] OP_INDEX = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_POS   = 2'd3;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CPR      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RPM_GAIN = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RPS_GAIN = 2'd3;

  // configuration reset values
  localparam logic [20:0] CPR_RESET      = 21'd4096;
  localparam logic [7:0]  POLE_RESET     = 8'd1;
  localparam logic [31:0] RPM_GAIN_RESET = 32'd96000;
  localparam logic [31:0] RPS_GAIN_RESET = 32'd1600;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] counter_value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] total_count;
    logic signed [15:0] delta_count;
    logic               direction;
    logic signed [31:0] shaft_rpm;
    logic signed [31:0] shaft_rps;
    logic [15:0]        mech_angle;
    logic [15:0]        elec_angle;
    logic [31:0]        index_count;
  } out_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_UPDATE,
    CMD_MUL_RPM,
    CMD_MUL_RPS,
    CMD_SAT_RPS,
    CMD_DIV_INIT,
    CMD_MOD_STEP,
    CMD_FIX,
    CMD_FRAC_STEP,
    CMD_ELEC
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic accept;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cpr_zero;
  } sts_t;

endpackage

// ----- sv/qpst_ctrl.sv -----
module qpst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  output logic             result_valid,
  input  logic             result_ready,
  input  qpst_pkg::sts_t   sts,
  output qpst_pkg::ctl_t   ctl
);

  localparam int MOD_CYCLES  = 16;
  localparam int FRAC_CYCLES = 8;
  localparam int CNT_W       = $clog2(MOD_CYCLES);
  localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(MOD_CYCLES - 1);
  localparam logic [CNT_W-1:0] FRAC_LAST = CNT_W'(FRAC_CYCLES - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPDATE,
    S_MUL_RPM,
    S_MUL_RPS,
    S_SAT_RPS,
    S_DIV_INIT,
    S_MOD,
    S_FIX,
    S_FRAC,
    S_ELEC,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign sample_ready = (state == S_IDLE) && !rst;

  always_comb begin
    ctl.accept   = sample_valid && sample_ready;
    ctl.load_out = (state == S_DONE) && (!result_valid || result_ready);
    case (state)
      S_UPDATE:   ctl.cmd = qpst_pkg::CMD_UPDATE;
      S_MUL_RPM:  ctl.cmd = qpst_pkg::CMD_MUL_RPM;
      S_MUL_RPS:  ctl.cmd = qpst_pkg::CMD_MUL_RPS;
      S_SAT_RPS:  ctl.cmd = qpst_pkg::CMD_SAT_RPS;
      S_DIV_INIT: ctl.cmd = qpst_pkg::CMD_DIV_INIT;
      S_MOD:      ctl.cmd = qpst_pkg::CMD_MOD_STEP;
      S_FIX:      ctl.cmd = qpst_pkg::CMD_FIX;
      S_FRAC:     ctl.cmd = qpst_pkg::CMD_FRAC_STEP;
      S_ELEC:     ctl.cmd = qpst_pkg::CMD_ELEC;
      default:    ctl.cmd = qpst_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (ctl.accept) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= (sts.op == qpst_pkg::OP_SPEED) ? S_MUL_RPM : S_DIV_INIT;
        end
        S_MUL_RPM: state <= S_MUL_RPS;
        S_MUL_RPS: state <= S_SAT_RPS;
        S_SAT_RPS: state <= S_DIV_INIT;
        S_DIV_INIT: begin
          cnt   <= '0;
          state <= sts.cpr_zero ? S_ELEC : S_MOD;
        end
        S_MOD: begin
          if (cnt == MOD_LAST) begin
            cnt   <= '0;
            state <= S_FIX;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIX: state <= S_FRAC;
        S_FRAC: begin
          if (cnt == FRAC_LAST) begin
            cnt   <= '0;
            state <= S_ELEC;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ELEC: state <= S_DONE;
        S_DONE: begin
          if (ctl.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/qpst_dpath.sv -----
module qpst_dpath #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  qpst_pkg::ctl_t                   ctl,
  output qpst_pkg::sts_t                   sts,
  input  qpst_pkg::in_t                    sample,
  input  logic                             cfg_we,
  input  logic [qpst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data,
  output qpst_pkg::out_t                   result
);

  localparam int SW = (COUNTER_WIDTH < 16) ? COUNTER_WIDTH : 16;

  // configuration
  logic [20:0] cpr;
  logic [7:0]  pp;
  logic [31:0] rpm_gain;
  logic [31:0] rps_gain;

  // tracker state
  logic [1:0]    op;
  logic [SW-1:0] cur;
  logic [SW-1:0] prev;
  logic [31:0]   total;
  logic [15:0]   last_delta;
  logic          dir;
  logic [31:0]   rpm;
  logic [31:0]   rps;
  logic [31:0]   index_pulses;

  // speed scaling
  logic [31:0] mag;
  logic        neg;
  logic [63:0] prod;

  // shift-subtract divider
  logic        tneg;
  logic [31:0] dvd;
  logic [20:0] rem;
  logic [15:0] quo;
  logic [15:0] elec;

  logic [COUNTER_WIDTH-1:0] diff;
  logic [31:0]              dx;
  logic                     b1;
  logic                     b0;
  logic [21:0]              s1;
  logic [21:0]              s2;

  function automatic logic [21:0] div_step(input logic [20:0] r, input logic b,
                                           input logic [20:0] c);
    logic [21:0] t;
    t = {r, b};
    if (t >= {1'b0, c}) begin
      return {1'b1, 21'(t - {1'b0, c})};
    end
    return {1'b0, t[20:0]};
  endfunction

  // round Q16.16 magnitude to Q24.8, then saturate with sign
  function automatic logic [31:0] sat_speed(input logic [63:0] p, input logic n);
    logic [63:0] q;
    q = (p + 64'd128) >> 8;
    if (n) begin
      if (q >= 64'h0000_0000_8000_0000) begin
        return 32'h8000_0000;
      end
      return 32'd0 - q[31:0];
    end
    if (q > 64'h0000_0000_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  // wrapped counter difference, sign-extended
  assign diff = COUNTER_WIDTH'(cur) - COUNTER_WIDTH'(prev);
  assign dx   = 32'($signed(diff));

  // two divider steps per cycle; fraction phase shifts in zeros
  assign b1 = (ctl.cmd == qpst_pkg::CMD_MOD_STEP) ? dvd[31] : 1'b0;
  assign b0 = (ctl.cmd == qpst_pkg::CMD_MOD_STEP) ? dvd[30] : 1'b0;
  assign s1 = div_step(rem, b1, cpr);
  assign s2 = div_step(s1[20:0], b0, cpr);

  assign sts.op       = op;
  assign sts.cpr_zero = (cpr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cpr      <= qpst_pkg::CPR_RESET;
      pp       <= qpst_pkg::POLE_RESET;
      rpm_gain <= qpst_pkg::RPM_GAIN_RESET;
      rps_gain <= qpst_pkg::RPS_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qpst_pkg::CFG_CPR:      cpr      <= cfg_data[20:0];
        qpst_pkg::CFG_POLE:     pp       <= cfg_data[7:0];
        qpst_pkg::CFG_RPM_GAIN: rpm_gain <= cfg_data;
        qpst_pkg::CFG_RPS_GAIN: rps_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev         <= '0;
      total        <= '0;
      last_delta   <= '0;
      dir          <= 1'b0;
      rpm          <= '0;
      rps          <= '0;
      index_pulses <= '0;
    end else begin
      case (ctl.cmd)
        qpst_pkg::CMD_UPDATE: begin
          case (op)
            qpst_pkg::OP_SPEED: begin
              last_delta <= dx[15:0];
              total      <= total + dx;
              prev       <= cur;
              dir        <= dx[31];
            end
            qpst_pkg::OP_INDEX: begin
              index_pulses <= index_pulses + 32'd1;
            end
            qpst_pkg::OP_CLEAR: begin
              prev         <= '0;
              total        <= '0;
              last_delta   <= '0;
              rpm          <= '0;
              rps          <= '0;
              index_pulses <= '0;
            end
            default: begin
              total <= total + dx;
              prev  <= cur;
            end
          endcase
        end
        qpst_pkg::CMD_MUL_RPS: rpm <= sat_speed(prod, neg);
        qpst_pkg::CMD_SAT_RPS: rps <= sat_speed(prod, neg);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op  <= sample.operation;
      cur <= sample.counter_value[SW-1:0];
    end
    case (ctl.cmd)
      qpst_pkg::CMD_UPDATE: begin
        neg <= dx[31];
        mag <= dx[31] ? (32'd0 - dx) : dx;
      end
      qpst_pkg::CMD_MUL_RPM: prod <= mag * rpm_gain;
      qpst_pkg::CMD_MUL_RPS: prod <= mag * rps_gain;
      qpst_pkg::CMD_DIV_INIT: begin
        tneg <= total[31];
        dvd  <= total[31] ? (32'd0 - total) : total;
        rem  <= '0;
        quo  <= '0;
      end
      qpst_pkg::CMD_MOD_STEP: begin
        dvd <= {dvd[29:0], 2'b00};
        rem <= s2[20:0];
      end
      qpst_pkg::CMD_FIX: begin
        // floor modulo: a negative total with a remainder wraps up to cpr
        if (tneg && (rem != '0)) begin
          rem <= cpr - rem;
        end
      end
      qpst_pkg::CMD_FRAC_STEP: begin
        rem <= s2[20:0];
        quo <= {quo[13:0], s1[21], s2[21]};
      end
      qpst_pkg::CMD_ELEC: elec <= 16'(quo * pp);
      default: ;
    endcase
    if (ctl.load_out) begin
      result.total_count <= total;
      result.delta_count <= last_delta;
      result.direction   <= dir;
      result.shaft_rpm   <= rpm;
      result.shaft_rps   <= rps;
      result.mech_angle  <= quo;
      result.elec_angle  <= elec;
      result.index_count <= index_pulses;
    end
  end

endmodule

// ----- sv/quadrature_position_speed_tracker.sv -----
// a speed sample word runs update, two gain multiplies and saturation, then the divider; other
//   words go from the update to the 2-bit-per-cycle shift-subtract divider (floor modulo pass,
//   then angle fraction pass, skipped if cpr is zero); no new word is taken before the result is loaded
// a finished result waits in the output register while the next word is accepted
// reset (synchronous, active high) clears position, delta, direction, speeds and index count, and loads the default
//   configuration: 4096 counts per turn, 1 pole pair, gains 96000 and 1600
module quadrature_position_speed_tracker #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // sample words
  input  logic                             sample_valid,
  output logic                             sample_ready,
  input  qpst_pkg::in_t                    sample,
  // result words
  output logic                             result_valid,
  input  logic                             result_ready,
  output qpst_pkg::out_t                   result,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qpst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                      cfg_data
);

  qpst_pkg::ctl_t ctl;
  qpst_pkg::sts_t sts;
  logic           cfg_we;

  // config writes are always accepted outside reset
  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;

  // controller: sequences update, two gain multiplies (speed words only), modulo and fraction passes
  qpst_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .ctl          (ctl)
  );

  // datapath: tracker state, shared multiplier, shift-subtract divider, output register
  qpst_dpath #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .sample    (sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

`ifndef SYNTH
  // one word in flight: accepting closes the input until the result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("input still open after accepting a word");

  // every accepted word starts with a state update
  a_update_follows: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> ctl.cmd == qpst_pkg::CMD_UPDATE)
    else $error("accepted word did not start an update");

  // a new result is only produced by a busy block
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(sample_ready))
    else $error("result appeared while the block was idle");
`endif

endmodule

// ----- test/quadrature_position_speed_tracker_test.sv -----
`timescale 1ns / 100ps

// predicts every result word of the tracker and checks the words that come back in order
class position_scoreboard;
  logic [20:0] cpr;
  logic [7:0]  poles;
  logic [31:0] rpm_gain;
  logic [31:0] rps_gain;

  logic [15:0]        prev_count;
  logic [31:0]        total;
  logic signed [15:0] last_delta;
  logic               reverse;
  logic [31:0]        rpm;
  logic [31:0]        rps;
  logic [31:0]        pulses;

  qpst_pkg::out_t pending_readings[$];
  int errors;

  function new();
    errors = 0;
    cpr = qpst_pkg::CPR_RESET;
    poles = qpst_pkg::POLE_RESET;
    rpm_gain = qpst_pkg::RPM_GAIN_RESET;
    rps_gain = qpst_pkg::RPS_GAIN_RESET;
    prev_count = '0;
    total = '0;
    last_delta = '0;
    reverse = 1'b0;
    rpm = '0;
    rps = '0;
    pulses = '0;
  endfunction

  function void write_reg(logic [qpst_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
    case (idx)
      qpst_pkg::CFG_CPR:      cpr = data[20:0];
      qpst_pkg::CFG_POLE:     poles = data[7:0];
      qpst_pkg::CFG_RPM_GAIN: rpm_gain = data;
      qpst_pkg::CFG_RPS_GAIN: rps_gain = data;
      default: ;
    endcase
  endfunction

  // delta times a Q16.16 gain, rounded half away from zero to Q24.8, saturated
  function logic [31:0] to_q24_8(logic signed [15:0] d, logic [31:0] gain);
    longint     dl;
    logic [63:0] mag;
    logic [63:0] q;
    dl = d;
    mag = (dl < 0) ? 64'(-dl) : 64'(dl);
    q = (mag * {32'd0, gain} + 64'd128) >> 8;
    if (dl < 0) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function void take_sample(qpst_pkg::in_t w);
    qpst_pkg::out_t     want;
    logic signed [15:0] step;
    logic [15:0]        mech;
    longint             span;
    longint             wrapped;
    longint             rem;
    step = w.counter_value - prev_count;
    case (w.operation)
      qpst_pkg::OP_SPEED: begin
        last_delta = step;
        total = total + {{16{step[15]}}, step};
        prev_count = w.counter_value;
        reverse = step[15];
        rpm = to_q24_8(step, rpm_gain);
        rps = to_q24_8(step, rps_gain);
      end
      qpst_pkg::OP_INDEX: pulses = pulses + 32'd1;
      qpst_pkg::OP_CLEAR: begin
        // direction survives a clear
        prev_count = '0;
        total = '0;
        last_delta = '0;
        rpm = '0;
        rps = '0;
        pulses = '0;
      end
      default: begin
        total = total + {{16{step[15]}}, step};
        prev_count = w.counter_value;
      end
    endcase
    span = cpr;
    if (span == 0) begin
      mech = '0;
    end else begin
      wrapped = $signed(total);
      rem = wrapped % span;
      if (rem < 0) rem = rem + span;
      mech = 16'((rem << 16) / span);
    end
    want.total_count = total;
    want.delta_count = last_delta;
    want.direction   = reverse;
    want.shaft_rpm   = rpm;
    want.shaft_rps   = rps;
    want.mech_angle  = mech;
    want.elec_angle  = 16'(mech * poles);
    want.index_count = pulses;
    pending_readings.push_back(want);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(qpst_pkg::out_t r);
    qpst_pkg::out_t want;
    if (pending_readings.size() == 0) begin
      $error("result word with no reading pending: %0h", r);
      errors++;
      return;
    end
    want = pending_readings.pop_front();
    compare_field("total_count", want.total_count, r.total_count);
    compare_field("delta_count", want.delta_count, r.delta_count);
    compare_field("direction", want.direction, r.direction);
    compare_field("shaft_rpm", want.shaft_rpm, r.shaft_rpm);
    compare_field("shaft_rps", want.shaft_rps, r.shaft_rps);
    compare_field("mech_angle", want.mech_angle, r.mech_angle);
    compare_field("elec_angle", want.elec_angle, r.elec_angle);
    compare_field("index_count", want.index_count, r.index_count);
  endfunction

  function int outstanding();
    return pending_readings.size();
  endfunction
endclass

module quadrature_position_speed_tracker_test;

  // cycles with no accepted word before the run is declared hung;
  // the long receiver hold-off below stays well under this
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_WORDS = 100;
  localparam int PHASES = 9;

  logic           clk;
  logic           rst;
  logic           sample_valid;
  logic           sample_ready;
  qpst_pkg::in_t  sample;
  logic           result_valid;
  logic           result_ready;
  qpst_pkg::out_t result;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [qpst_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]    cfg_data;

  position_scoreboard tracker;

  // idling knobs, percent of cycles, changed between phases
  int sender_idle_pct;
  int recv_stall_pct;
  // long receiver hold-off, counted down by the receiver process
  int hold_cycles;
  int quiet_cycles;

  // stimulus-side view of the counter, keeps random sequences well formed
  logic [15:0] stim_count;
  int          velocity;

  quadrature_position_speed_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // hang detector: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: ready changes on the falling edge, words are taken on the rising edge
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_ready = 1'b0;
        hold_cycles--;
      end else begin
        result_ready = ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (result_valid && result_ready) tracker.check_result(result);
    end
  end

  // offer one sample word, with a random gap first; returns on the falling edge
  // after acceptance with valid still high, so the caller either offers the
  // next word or lowers valid
  task automatic send_word(qpst_pkg::in_t w);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < sender_idle_pct) begin
      sample_valid = 1'b0;
      gap++;
      @(negedge clk);
    end
    sample_valid = 1'b1;
    sample = w;
    do @(posedge clk); while (!sample_ready);
    tracker.take_sample(w);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [qpst_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  // let every pending result come back, then a few quiet cycles
  task automatic wait_drained();
    sample_valid = 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // registers are only touched while the tracker is idle
  task automatic set_config(logic [31:0] cpr_word, logic [31:0] pole_word,
                            logic [31:0] rpm_word, logic [31:0] rps_word);
    wait_drained();
    write_reg(qpst_pkg::CFG_CPR, cpr_word);
    write_reg(qpst_pkg::CFG_POLE, pole_word);
    write_reg(qpst_pkg::CFG_RPM_GAIN, rpm_word);
    write_reg(qpst_pkg::CFG_RPS_GAIN, rps_word);
    cfg_valid = 1'b0;
  endtask

  // mostly a shaft turning at a drifting speed, with jumps, extreme deltas,
  // index pulses and the odd clear mixed in
  function automatic qpst_pkg::in_t random_word();
    qpst_pkg::in_t w;
    int            pick;
    pick = $urandom_range(99);
    if (pick < 55) w.operation = qpst_pkg::OP_SPEED;
    else if (pick < 75) w.operation = qpst_pkg::OP_POS;
    else if (pick < 93) w.operation = qpst_pkg::OP_INDEX;
    else w.operation = qpst_pkg::OP_CLEAR;
    if ($urandom_range(19) == 0) velocity = int'($urandom_range(4000)) - 2000;
    pick = $urandom_range(99);
    if (pick < 65) w.counter_value = stim_count + 16'(velocity + int'($urandom_range(20)) - 10);
    else if (pick < 80) w.counter_value = 16'($urandom);
    else if (pick < 90) w.counter_value = stim_count + ($urandom_range(1) ? 16'h7FFF : 16'h8000);
    else w.counter_value = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
    if (w.operation == qpst_pkg::OP_CLEAR) stim_count = '0;
    else if (w.operation != qpst_pkg::OP_INDEX) stim_count = w.counter_value;
    return w;
  endfunction

  initial begin
    tracker = new();
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    stim_count = '0;
    velocity = 37;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default configuration: zero delta, full-scale deltas both ways, counter wrap,
    // index pulses, position-only samples, clear keeping a reverse direction
    send_word('{qpst_pkg::OP_SPEED, 16'h0000});
    send_word('{qpst_pkg::OP_SPEED, 16'h7FFF});
    send_word('{qpst_pkg::OP_SPEED, 16'h0000});
    send_word('{qpst_pkg::OP_SPEED, 16'h8000});
    send_word('{qpst_pkg::OP_INDEX, 16'hFFFF});
    send_word('{qpst_pkg::OP_POS, 16'hFFFF});
    send_word('{qpst_pkg::OP_POS, 16'h0001});
    send_word('{qpst_pkg::OP_CLEAR, 16'h5A5A});
    send_word('{qpst_pkg::OP_SPEED, 16'hFFF0});
    send_word('{qpst_pkg::OP_CLEAR, 16'h0000});
    send_word('{qpst_pkg::OP_INDEX, 16'h0000});

    // zero counts per turn, zero pole pairs, rounding ties and saturation
    set_config(32'd0, 32'd0, 32'd128, 32'hFFFF_FFFF);
    send_word('{qpst_pkg::OP_CLEAR, 16'h0000});
    send_word('{qpst_pkg::OP_SPEED, 16'h0001});
    send_word('{qpst_pkg::OP_SPEED, 16'h0000});
    send_word('{qpst_pkg::OP_SPEED, 16'h7FFF});
    send_word('{qpst_pkg::OP_SPEED, 16'hFFFF});
    send_word('{qpst_pkg::OP_SPEED, 16'h7FFF});

    // widest turn (upper bits masked off) and the most pole pairs
    set_config(32'hFFFF_FFFF, 32'h0000_00FF, 32'hFFFF_FFFF, 32'd0);
    send_word('{qpst_pkg::OP_CLEAR, 16'h0000});
    send_word('{qpst_pkg::OP_POS, 16'hFFFF});
    send_word('{qpst_pkg::OP_SPEED, 16'h7FFE});
    send_word('{qpst_pkg::OP_INDEX, 16'h1234});
    send_word('{qpst_pkg::OP_SPEED, 16'h0000});

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: set_config(32'd4096, 32'd1, 32'd96000, 32'd1600);
        1: set_config(32'd4, 32'd255, 32'hFFFF_FFFF, 32'd0);
        2: set_config(32'hFFFF_FFFF, 32'h0000_0100, 32'd0, 32'hFFFF_FFFF);
        3: set_config(32'h0010_0000, 32'd7, $urandom, $urandom_range(200000));
        4: set_config(32'd0, 32'd3, 32'd96000, 32'd1600);
        5: set_config(32'd3, 32'd4, $urandom_range(100000), $urandom);
        6: set_config($urandom_range(5000, 4), $urandom, $urandom, $urandom);
        7: set_config($urandom, $urandom, $urandom_range(50000), $urandom_range(5000));
        default: set_config(32'd4096, $urandom_range(255, 1), $urandom, $urandom);
      endcase
      stim_count = tracker.prev_count;
      // idling modes rotate: none, sender idle, receiver stall, both
      case (phase % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin sender_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // receiver backs off for a long time while words keep coming,
      // so the tracker fills up and drops sample_ready
      if (phase == 0) hold_cycles = HOLD_OFF_CYCLES;
      for (int n = 0; n < PHASE_WORDS; n++) send_word(random_word());
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
